// ----- rtl/i2cm_pkg.sv -----
// I2C master register file: shared request/result types, register and
// command bit positions. No dependencies.
`default_nettype none

package i2cm_pkg;

  // Register offsets seen by the processor
  typedef enum logic [2:0] {
    REG_PRE_LO = 3'd0,
    REG_PRE_HI = 3'd1,
    REG_CTRL   = 3'd2,
    REG_TXRX   = 3'd3,
    REG_CMDSR  = 3'd4
  } reg_idx_e;

  // Access kind
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Command issued on the bus side
  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_START = 2'd1,
    BUS_WRITE = 2'd2,
    BUS_READ  = 2'd3
  } bus_cmd_e;

  // Control register bits
  localparam int unsigned CtrlEnBit  = 7;
  localparam int unsigned CtrlIenBit = 6;

  // Command register bits
  localparam int unsigned CmdStaBit  = 7;
  localparam int unsigned CmdStoBit  = 6;
  localparam int unsigned CmdRdBit   = 5;
  localparam int unsigned CmdWrBit   = 4;
  localparam int unsigned CmdAckBit  = 3;
  localparam int unsigned CmdIackBit = 0;

  typedef struct packed {
    logic       op;
    logic [2:0] reg_index;
    logic [7:0] write_byte;
    logic       target_ack;
    logic [7:0] target_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq_pulse;
    logic [1:0] bus_command;
    logic [7:0] bus_byte;
    logic       bus_stop;
    logic       master_nack;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/i2cm_core.sv -----
// I2C master register file: register state and per-request decode.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_core import i2cm_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic step_i,   // commit the request below
  input  wire  req_t req_i,
  output rsp_t       rsp_o
);

  logic [7:0] pre_lo_q, pre_lo_d;
  logic [7:0] pre_hi_q, pre_hi_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] rx_q, rx_d;
  logic       rxack_q, rxack_d;
  logic       busy_q, busy_d;
  logic       irq_flag_q, irq_flag_d;
  logic       nack_req_q, nack_req_d;

  logic       enabled;
  logic       flag_mid;
  logic [7:0] wb;
  rsp_t       rsp;

  assign enabled = ctrl_q[CtrlEnBit];
  assign wb      = req_i.write_byte;

  always_comb begin
    pre_lo_d   = pre_lo_q;
    pre_hi_d   = pre_hi_q;
    ctrl_d     = ctrl_q;
    tx_d       = tx_q;
    rx_d       = rx_q;
    rxack_d    = rxack_q;
    busy_d     = busy_q;
    irq_flag_d = irq_flag_q;
    nack_req_d = nack_req_q;
    flag_mid   = irq_flag_q;
    rsp        = '0;

    if (req_i.op == OP_READ) begin
      case (reg_idx_e'(req_i.reg_index))
        REG_PRE_LO: rsp.read_byte = pre_lo_q;
        REG_PRE_HI: rsp.read_byte = pre_hi_q;
        REG_CTRL:   rsp.read_byte = ctrl_q;
        REG_TXRX:   rsp.read_byte = rx_q;
        // AL and TIP always zero here
        REG_CMDSR:  rsp.read_byte = {rxack_q, busy_q, 5'b0, irq_flag_q};
        default:    rsp.read_byte = '0;
      endcase
    end else begin
      case (reg_idx_e'(req_i.reg_index))
        REG_PRE_LO: pre_lo_d = wb;
        REG_PRE_HI: pre_hi_d = wb;
        REG_CTRL:   ctrl_d   = wb;
        REG_TXRX: begin
          if (enabled) tx_d = wb;
        end
        REG_CMDSR: begin
          if (enabled) begin
            if (wb[CmdIackBit]) flag_mid = 1'b0;
            irq_flag_d = flag_mid;
            if (wb[CmdStaBit] || wb[CmdWrBit] || wb[CmdRdBit]) begin
              rxack_d = ~req_i.target_ack;
              if (wb[CmdStaBit]) begin
                rsp.bus_command = BUS_START;
                rsp.bus_byte    = {1'b0, tx_q[7:1]};
                busy_d          = req_i.target_ack;
              end else if (wb[CmdWrBit]) begin
                rsp.bus_command = BUS_WRITE;
                rsp.bus_byte    = tx_q;
              end else begin
                rsp.bus_command = BUS_READ;
                if (req_i.target_ack) rx_d = req_i.target_byte;
                nack_req_d      = wb[CmdAckBit];
                rsp.master_nack = wb[CmdAckBit];
              end
              rsp.irq_pulse = ctrl_q[CtrlIenBit] & ~flag_mid;
              irq_flag_d    = 1'b1;
            end
            if (wb[CmdStoBit]) begin
              rsp.bus_stop = 1'b1;
              busy_d       = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_o = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_lo_q   <= '0;
      pre_hi_q   <= '0;
      ctrl_q     <= '0;
      tx_q       <= '0;
      rx_q       <= '0;
      rxack_q    <= 1'b0;
      busy_q     <= 1'b0;
      irq_flag_q <= 1'b0;
      nack_req_q <= 1'b0;
    end else if (step_i) begin
      pre_lo_q   <= pre_lo_d;
      pre_hi_q   <= pre_hi_d;
      ctrl_q     <= ctrl_d;
      tx_q       <= tx_d;
      rx_q       <= rx_d;
      rxack_q    <= rxack_d;
      busy_q     <= busy_d;
      irq_flag_q <= irq_flag_d;
      nack_req_q <= nack_req_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_register_file.sv -----
// I2C master register file, top level: input stage, register core and
// result register. Depends on i2cm_pkg and i2cm_core.
`default_nettype none

// One processor access per request: read or write of prescale lo/hi,
// control, transmit/receive or command/status. Every request yields exactly
// one result, via the input register and then the result register.
// The block takes a new request every cycle while out_stall_i is low; the
// decode between the input and result registers is combinational.
// A result holds on out_rsp_o while out_stall_i is high; the input stage
// keeps taking one more request meanwhile, then in_stall_o rises. Writes to
// transmit or command are dropped while control bit 7 is clear. START, WRITE
// and READ set the interrupt flag and pulse irq_pulse when control bit 6 is
// set and the flag was clear after any IACK in the same write. Status reads
// return RXACK, BUSY and IF; AL and TIP read as zero. Bus timing and the
// prescaler are outside this block.
module i2c_master_register_file import i2cm_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  input  wire  req_t in_req_i,
  output logic       out_valid_o,
  input  wire  logic out_stall_i,
  output rsp_t       out_rsp_o
);

  logic in_valid_q;
  req_t in_req_q;
  logic out_valid_q;
  rsp_t out_rsp_q;
  rsp_t core_rsp;
  logic step;
  logic in_take;

  // Stage moves on whenever the result register is free or being emptied
  assign step       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~step;
  assign in_take    = in_valid_i & ~in_stall_o;

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .rsp_o  (core_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_req_q <= in_req_i;
    if (step) out_rsp_q <= core_rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ----- verif/tb_i2c_master_register_file.sv -----
`timescale 1ns / 100ps
// Testbench for i2c_master_register_file: directed and random register accesses,
// results checked against a behavioral copy of the register front end.
// Depends on i2cm_pkg and the RTL of i2c_master_register_file.

module tb_i2c_master_register_file;
  import i2cm_pkg::*;

  // Status byte layout (AL and TIP always read as zero)
  localparam int unsigned StRxackBit = 7;
  localparam int unsigned StBusyBit  = 6;
  localparam int unsigned StIfBit    = 0;

  localparam int unsigned IdlePct       = 27;
  localparam int unsigned DirectedCount = 24;
  localparam int unsigned BurstCount    = 200;
  localparam int unsigned TotalCount    = DirectedCount + 850;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ReportLimit   = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_req    = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  // Set during the back-to-back stretch: neither side idles
  logic quiet = 1'b0;

  // Shadow copy of the register file
  logic [7:0] prelo_q, prehi_q, ctrl_q, tx_q, rx_q;
  logic       rxack_q, busy_q, irq_flag_q, nack_req_q;

  rsp_t        expected_rsp_q[$];
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  i2c_master_register_file u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, logic [2:0] idx, logic [7:0] wb,
                                    logic ack, logic [7:0] tb);
    req_t r;
    r.op          = op;
    r.reg_index   = idx;
    r.write_byte  = wb;
    r.target_ack  = ack;
    r.target_byte = tb;
    return r;
  endfunction

  // Apply one access to the shadow registers and return the result it yields
  function automatic rsp_t predict_access(req_t r);
    rsp_t       rsp;
    logic [7:0] wb;
    logic       core_on;
    rsp     = '0;
    wb      = r.write_byte;
    core_on = ctrl_q[CtrlEnBit];
    if (r.op == OP_READ) begin
      case (reg_idx_e'(r.reg_index))
        REG_PRE_LO: rsp.read_byte = prelo_q;
        REG_PRE_HI: rsp.read_byte = prehi_q;
        REG_CTRL:   rsp.read_byte = ctrl_q;
        REG_TXRX:   rsp.read_byte = rx_q;
        REG_CMDSR: begin
          rsp.read_byte[StRxackBit] = rxack_q;
          rsp.read_byte[StBusyBit]  = busy_q;
          rsp.read_byte[StIfBit]    = irq_flag_q;
        end
        default:    rsp.read_byte = '0;
      endcase
    end else begin
      case (reg_idx_e'(r.reg_index))
        REG_PRE_LO: prelo_q = wb;
        REG_PRE_HI: prehi_q = wb;
        REG_CTRL:   ctrl_q  = wb;
        REG_TXRX: begin
          if (core_on) tx_q = wb;
        end
        REG_CMDSR: begin
          if (core_on) begin
            if (wb[CmdIackBit]) irq_flag_q = 1'b0;
            // START wins over WRITE, WRITE over READ
            if (wb[CmdStaBit] || wb[CmdWrBit] || wb[CmdRdBit]) begin
              if (wb[CmdStaBit]) begin
                rsp.bus_command = BUS_START;
                rsp.bus_byte    = {1'b0, tx_q[7:1]};
                rxack_q         = !r.target_ack;
                busy_q          = r.target_ack;
              end else if (wb[CmdWrBit]) begin
                rsp.bus_command = BUS_WRITE;
                rsp.bus_byte    = tx_q;
                rxack_q         = !r.target_ack;
              end else begin
                rsp.bus_command = BUS_READ;
                if (r.target_ack) rx_q = r.target_byte;
                rxack_q         = !r.target_ack;
                nack_req_q      = wb[CmdAckBit];
                rsp.master_nack = wb[CmdAckBit];
              end
              rsp.irq_pulse = ctrl_q[CtrlIenBit] && !irq_flag_q;
              irq_flag_q    = 1'b1;
            end
            if (wb[CmdStoBit]) begin
              rsp.bus_stop = 1'b1;
              busy_q       = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    return rsp;
  endfunction

  // Present one request, hold it until accepted, then queue its expected result.
  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_request(input req_t r);
    if (!quiet) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    expected_rsp_q.push_back(predict_access(r));
    sent_count++;
  endtask

  task automatic compare_field(input string fname, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("%0t: result %0d %s expected %0h, got %0h",
                 $realtime, checked_count, fname, exp_v, got_v);
    end
  endtask

  // Result side: random stall, field-by-field check of each accepted result
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: result with no request outstanding, got %0h",
                     $realtime, out_rsp);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          compare_field("read_byte",   exp_rsp.read_byte,   out_rsp.read_byte);
          compare_field("irq_pulse",   8'(exp_rsp.irq_pulse),
                        8'(out_rsp.irq_pulse));
          compare_field("bus_command", 8'(exp_rsp.bus_command),
                        8'(out_rsp.bus_command));
          compare_field("bus_byte",    exp_rsp.bus_byte,    out_rsp.bus_byte);
          compare_field("bus_stop",    8'(exp_rsp.bus_stop),
                        8'(out_rsp.bus_stop));
          compare_field("master_nack", 8'(exp_rsp.master_nack),
                        8'(out_rsp.master_nack));
        end
        checked_count++;
      end
      out_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  // Command byte with the given command bits plus random ACK, IACK and spare bits
  function automatic logic [7:0] cmd_with_extras(logic [7:0] base);
    return base | 8'($urandom_range(15));
  endfunction

  // Well-formed transfer: control (mostly enabled), address, START, a few data commands, STOP
  task automatic run_transfer();
    logic [7:0] ctrl;
    int         n_data;
    ctrl            = 8'($urandom_range(255));
    ctrl[CtrlEnBit] = ($urandom_range(99) < 85);
    n_data          = $urandom_range(1, 4);
    send_request(make_req(OP_WRITE, REG_CTRL, ctrl, 1'($urandom_range(1)),
                          8'($urandom_range(255))));
    send_request(make_req(OP_WRITE, REG_TXRX, 8'($urandom_range(255)),
                          1'($urandom_range(1)), 8'($urandom_range(255))));
    send_request(make_req(OP_WRITE, REG_CMDSR, cmd_with_extras(8'h80),
                          ($urandom_range(99) < 80), 8'($urandom_range(255))));
    repeat (n_data) begin
      if ($urandom_range(1)) begin
        send_request(make_req(OP_WRITE, REG_TXRX, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 8'($urandom_range(255))));
        send_request(make_req(OP_WRITE, REG_CMDSR, cmd_with_extras(8'h10),
                              ($urandom_range(99) < 80), 8'($urandom_range(255))));
      end else begin
        send_request(make_req(OP_WRITE, REG_CMDSR, cmd_with_extras(8'h20),
                              ($urandom_range(99) < 80), 8'($urandom_range(255))));
        send_request(make_req(OP_READ, REG_TXRX, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 8'($urandom_range(255))));
      end
      if ($urandom_range(2) == 0)
        send_request(make_req(OP_READ, REG_CMDSR, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 8'($urandom_range(255))));
    end
    // STOP, sometimes folded into a last data command
    send_request(make_req(OP_WRITE, REG_CMDSR,
                          cmd_with_extras(8'h40 | 8'($urandom_range(3) << 4)),
                          ($urandom_range(99) < 80), 8'($urandom_range(255))));
    send_request(make_req(OP_READ, REG_CMDSR, 8'($urandom_range(255)),
                          1'($urandom_range(1)), 8'($urandom_range(255))));
  endtask

  task automatic send_noise();
    send_request(make_req(op_e'($urandom_range(1)), 3'($urandom_range(7)),
                          8'($urandom_range(255)), 1'($urandom_range(1)),
                          8'($urandom_range(255))));
  endtask

  // All registers, the unused indexes too, read zero after reset
  task automatic test_reset_values();
    for (int i = 0; i < 8; i++)
      send_request(make_req(OP_READ, 3'(i), 8'hFF, 1'b1, 8'hFF));
  endtask

  // Core disabled: transmit and command writes are dropped
  task automatic test_disabled_core();
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'hF9, 1'b1, 8'hFF));
    send_request(make_req(OP_WRITE, REG_TXRX, 8'hFF, 1'b1, 8'hFF));
  endtask

  // Prescale extremes, write to an unused index
  task automatic test_register_access();
    send_request(make_req(OP_WRITE, REG_PRE_LO, 8'hFF, 1'b0, 8'h00));
    send_request(make_req(OP_WRITE, REG_PRE_HI, 8'h00, 1'b0, 8'h00));
    send_request(make_req(OP_WRITE, 3'd7, 8'hFF, 1'b1, 8'hFF));
  endtask

  // Enabled core with interrupts: each command, priorities, NACK paths, STOP
  task automatic test_commands();
    send_request(make_req(OP_WRITE, REG_CTRL, 8'hC0, 1'b0, 8'h00));
    send_request(make_req(OP_WRITE, REG_TXRX, 8'hA5, 1'b0, 8'h00));
    // START answered with NACK: busy cleared again
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'h80, 1'b0, 8'h00));
    send_request(make_req(OP_READ, REG_CMDSR, 8'h00, 1'b0, 8'h00));
    // IACK plus START, WRITE and READ together: START wins, flag rearmed
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'hB1, 1'b1, 8'h3C));
    // WRITE over READ, flag already set so no pulse
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'h30, 1'b1, 8'h00));
    // READ with ack and NACK request after IACK
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'h29, 1'b1, 8'hFF));
    // READ without ack keeps the old receive byte
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'h20, 1'b0, 8'h00));
    send_request(make_req(OP_WRITE, REG_CMDSR, 8'h40, 1'b0, 8'h00));
    send_request(make_req(OP_READ, REG_TXRX, 8'h00, 1'b0, 8'h00));
    send_request(make_req(OP_READ, REG_CMDSR, 8'h00, 1'b0, 8'h00));
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    while (sent_count < DirectedCount + BurstCount) run_transfer();
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (sent_count < TotalCount) begin
      if ($urandom_range(99) < 75) run_transfer();
      else send_noise();
    end
  endtask

  initial begin
    prelo_q    = '0;
    prehi_q    = '0;
    ctrl_q     = '0;
    tx_q       = '0;
    rx_q       = '0;
    rxack_q    = 1'b0;
    busy_q     = 1'b0;
    irq_flag_q = 1'b0;
    nack_req_q = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_disabled_core();
    test_register_access();
    test_commands();
    test_back_to_back();
    test_random_traffic();
    in_valid <= 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
